### rtl/pjbc_pkg.sv
// pjbc_pkg: shared types, codes and defaults for the playback jitter buffer control core
// no dependencies; imported by playback_jitter_buffer_control_core
package pjbc_pkg;

  // default sizing
  localparam int unsigned MaxSlotsDef     = 128;
  localparam int unsigned FrameSamplesDef = 320;

  // field widths
  localparam int unsigned ActionW  = 3;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned BytesW   = 10;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned SamplesW = 9;
  localparam int unsigned FillW    = 8;
  localparam int unsigned GraceW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // stream bus widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // register reset values
  localparam logic [FillW-1:0]  CapacityRst = 8'd75;
  localparam logic [FillW-1:0]  InitFillRst = 8'd9;
  localparam logic [FillW-1:0]  RebufFillRst = 8'd2;
  localparam logic [GraceW-1:0] GraceRst    = 10'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY  = 2'd0,
    CFG_INIT_FILL = 2'd1,
    CFG_REBUF_FILL = 2'd2,
    CFG_GRACE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [ActionW-1:0] {
    ACT_BEGIN = 3'd0,
    ACT_PUSH  = 3'd1,
    ACT_END   = 3'd2,
    ACT_DROP  = 3'd3,
    ACT_POP   = 3'd4,
    ACT_TICK  = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED   = 4'd0,
    ST_INVALID    = 4'd1,
    ST_NOT_ACTIVE = 4'd2,
    ST_ENDING     = 4'd3,
    ST_FULL       = 4'd4,
    ST_GAP        = 4'd5,
    ST_REJECTED   = 4'd6,
    ST_NOT_READY  = 4'd7,
    ST_FRAME      = 4'd8,
    ST_FINISHED   = 4'd9
  } status_e;

  typedef struct packed {
    logic                stream_active;
    logic                stream_ending;
    logic                drop_pending;
    logic                has_started;
    logic                in_rebuffer;
    logic [SamplesW-1:0] tail_samples;
    logic [SeqW-1:0]     expected_sequence;
    logic [GraceW-1:0]   empty_tick_count;
  } flags_t;

endpackage

### rtl/playback_jitter_buffer_control_core.sv
// playback_jitter_buffer_control_core: control side of a playback jitter buffer
// depends on pjbc_pkg for codes, widths and register defaults
//
// usage:
//   slave stream: one action per item. tuser carries the action code (begin, push,
//   end, drop, pop, tick); tdata carries frame_sequence in bits 31:0 and frame_bytes
//   in bits 41:32 (upper bits zero). only push looks at tdata.
//   master stream: exactly one result item per input item, in order. tuser is the
//   status code, tlast marks the final popped frame of a stream, tdata carries
//   slot_samples in bits 8:0 and the discarded flag in bit 9.
//   config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock edge
//   (capacity, initial fill, rebuffer fill, grace ticks); write only while idle.
// path: an accepted item lands in the input register, is evaluated there against the
//   stream state, and its result is shown from the output register.
// throughput: one item per cycle while the output is not stalled; the state update is
//   a single pass of flag and counter logic, so nothing recirculates.
// reset: rst_ni clears the stream state, both pipeline valids and restores the
//   register defaults (75 / 9 / 2 / 30).
// stall: when m_axis_tready is low the result holds, the input register fills, and
//   s_axis_tready drops until the output drains.
module playback_jitter_buffer_control_core #(
  parameter int unsigned MAX_SLOTS     = pjbc_pkg::MaxSlotsDef,
  parameter int unsigned FRAME_SAMPLES = pjbc_pkg::FrameSamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [pjbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pjbc_pkg::CfgDataW-1:0] cfg_data_i,
  // action items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pjbc_pkg::InDataW-1:0]  s_axis_tdata,  // frame_sequence, frame_bytes
  input  logic [pjbc_pkg::ActionW-1:0]  s_axis_tuser,  // action
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pjbc_pkg::OutDataW-1:0] m_axis_tdata,  // slot_samples, discarded
  output logic [pjbc_pkg::StatusW-1:0]  m_axis_tuser,  // status
  output logic                          m_axis_tlast   // final frame mark
);
  import pjbc_pkg::*;

  localparam int unsigned SlotW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CmpW  = (SlotW > FillW) ? SlotW : FillW;
  localparam int unsigned LenW  = 12;  // holds 2 * FRAME_SAMPLES over the whole range

  localparam logic [CmpW-1:0]     MaxSlotsC   = CmpW'(MAX_SLOTS);
  localparam logic [LenW-1:0]     MaxBytesC   = LenW'(2 * FRAME_SAMPLES);
  localparam logic [LenW-1:0]     FrameLenC   = LenW'(FRAME_SAMPLES);
  localparam logic [SamplesW-1:0] FrameSampC  = SamplesW'(FRAME_SAMPLES);

  // configuration registers
  logic [FillW-1:0]  capacity_q, init_fill_q, rebuf_fill_q;
  logic [GraceW-1:0] grace_q;

  // input register
  logic               in_vld_q;
  logic [ActionW-1:0] in_act_q;
  logic [SeqW-1:0]    in_seq_q;
  logic [BytesW-1:0]  in_bytes_q;

  // stream state
  flags_t           st_q, st_d;
  logic [SlotW-1:0] slot_q, slot_d;

  // result register
  logic                out_vld_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [SamplesW-1:0] samples_q, samples_d;
  logic                last_q, last_d;
  logic                disc_q, disc_d;

  logic advance;   // input register moves into the result register
  logic in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= CapacityRst;
      init_fill_q  <= InitFillRst;
      rebuf_fill_q <= RebufFillRst;
      grace_q      <= GraceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAPACITY:   capacity_q   <= cfg_data_i[FillW-1:0];
        CFG_INIT_FILL:  init_fill_q  <= cfg_data_i[FillW-1:0];
        CFG_REBUF_FILL: rebuf_fill_q <= cfg_data_i[FillW-1:0];
        CFG_GRACE:      grace_q      <= cfg_data_i[GraceW-1:0];
        default:        ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_act_q   <= s_axis_tuser;
      in_seq_q   <= s_axis_tdata[SeqW-1:0];
      in_bytes_q <= s_axis_tdata[SeqW+BytesW-1:SeqW];
    end
  end

  // derived state terms
  logic [CmpW-1:0]     slot_ext, full_ext, cap_now;
  logic                tail_held, pop_ready, grace_wait, bad_len;
  logic [SamplesW-1:0] half_bytes;
  logic [GraceW-1:0]   tick_inc;

  always_comb begin
    slot_ext  = CmpW'(slot_q);
    tail_held = (st_q.tail_samples != '0);
    full_ext  = slot_ext - CmpW'(tail_held);
    cap_now   = (CmpW'(capacity_q) < MaxSlotsC) ? CmpW'(capacity_q) : MaxSlotsC;

    // pop readiness, first matching rule wins
    if (!st_q.stream_active) begin
      pop_ready = 1'b0;
    end else if (slot_q == '0) begin
      pop_ready = st_q.stream_ending;
    end else if (st_q.stream_ending) begin
      pop_ready = 1'b1;
    end else if (slot_q == SlotW'(1) && tail_held) begin
      pop_ready = 1'b0;
    end else if (!st_q.has_started) begin
      pop_ready = full_ext >= CmpW'(init_fill_q);
    end else if (st_q.in_rebuffer) begin
      pop_ready = full_ext >= CmpW'(rebuf_fill_q);
    end else begin
      pop_ready = 1'b1;
    end

    grace_wait = st_q.stream_active && st_q.has_started && (slot_q == '0) &&
                 !st_q.stream_ending && !st_q.drop_pending && !st_q.in_rebuffer;

    bad_len    = (in_bytes_q == '0) || in_bytes_q[0] ||
                 (LenW'(in_bytes_q) > MaxBytesC);
    half_bytes = in_bytes_q[BytesW-1:1];
    tick_inc   = st_q.empty_tick_count + GraceW'(1);
  end

  // next state and result for the item in the input register
  always_comb begin
    st_d      = st_q;
    slot_d    = slot_q;
    status_d  = ST_ACCEPTED;
    samples_d = '0;
    last_d    = 1'b0;
    disc_d    = 1'b0;

    unique case (action_e'(in_act_q))
      ACT_BEGIN: begin
        if (st_q.stream_active) begin
          status_d = ST_REJECTED;
        end else begin
          st_d               = '0;
          st_d.stream_active = 1'b1;
          slot_d             = '0;
        end
      end
      ACT_PUSH: begin
        priority if (bad_len) begin
          status_d = ST_INVALID;
        end else if (!st_q.stream_active) begin
          status_d = ST_NOT_ACTIVE;
        end else if (st_q.stream_ending || (slot_q != '0 && tail_held)) begin
          status_d = ST_ENDING;
        end else if (slot_ext >= cap_now) begin
          status_d = ST_FULL;
        end else if (in_seq_q != st_q.expected_sequence) begin
          status_d = ST_GAP;
        end else begin
          slot_d                 = slot_q + SlotW'(1);
          st_d.tail_samples      = (LenW'(half_bytes) != FrameLenC) ? half_bytes : '0;
          st_d.expected_sequence = in_seq_q + SeqW'(1);
          st_d.empty_tick_count  = '0;
        end
      end
      ACT_END: begin
        if (!st_q.stream_active || st_q.stream_ending) begin
          status_d = ST_REJECTED;
        end else begin
          st_d.stream_ending    = 1'b1;
          st_d.empty_tick_count = '0;
        end
      end
      ACT_DROP: begin
        if (!st_q.stream_active) begin
          status_d = ST_REJECTED;
        end else begin
          st_d.drop_pending     = 1'b1;
          slot_d                = '0;
          st_d.tail_samples     = '0;
          st_d.empty_tick_count = '0;
        end
      end
      ACT_POP: begin
        priority if (st_q.stream_active && st_q.drop_pending) begin
          // discarded finish, expected sequence survives
          status_d = ST_FINISHED;
          disc_d   = 1'b1;
          st_d     = '0;
          st_d.expected_sequence = st_q.expected_sequence;
          slot_d   = '0;
        end else if (!pop_ready) begin
          status_d = ST_NOT_READY;
        end else if (slot_q == '0) begin
          status_d = ST_FINISHED;
          st_d     = '0;
          st_d.expected_sequence = st_q.expected_sequence;
          slot_d   = '0;
        end else begin
          status_d = ST_FRAME;
          if (slot_q == SlotW'(1) && tail_held) begin
            samples_d         = st_q.tail_samples;
            st_d.tail_samples = '0;
          end else begin
            samples_d = FrameSampC;
          end
          slot_d                = slot_q - SlotW'(1);
          st_d.has_started      = 1'b1;
          st_d.in_rebuffer      = 1'b0;
          st_d.empty_tick_count = '0;
          // last held slot of an ending stream closes it
          if (st_q.stream_ending && slot_q == SlotW'(1)) begin
            last_d = 1'b1;
            st_d   = '0;
            st_d.expected_sequence = st_q.expected_sequence;
            slot_d = '0;
          end
        end
      end
      ACT_TICK: begin
        if (grace_wait) begin
          if (tick_inc >= grace_q) begin
            st_d.in_rebuffer      = 1'b1;
            st_d.empty_tick_count = '0;
          end else begin
            st_d.empty_tick_count = tick_inc;
          end
        end else begin
          st_d.empty_tick_count = '0;
        end
      end
      default: begin
        status_d = ST_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q   <= st_d;
        slot_q <= slot_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q  <= status_d;
      samples_q <= samples_d;
      last_q    <= last_d;
      disc_q    <= disc_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {{(OutDataW-SamplesW-1){1'b0}}, disc_q, samples_q};

endmodule
